[hdl/playfair_encrypt_macros.svh]
// assertion macros shared by the playfair encryption modules
`ifndef PLAYFAIR_ENCRYPT_MACROS_SVH
`define PLAYFAIR_ENCRYPT_MACROS_SVH

// condition holds at every clock edge outside reset
`define PFE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pfe assertion failed");

// consequent holds in the same cycle as the antecedent
`define PFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfe assertion failed");

// consequent holds in the cycle after the antecedent
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfe assertion failed");

`endif

[hdl/pfe_pkg.sv]
// types, constants and helper functions of the playfair encryption block
package pfe_pkg;

   localparam logic [1:0] OP_KEY = 2'd0;
   localparam logic [1:0] OP_KEY_DONE = 2'd1;
   localparam logic [1:0] OP_MSG = 2'd2;
   localparam logic [1:0] OP_MSG_END = 2'd3;

   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_Z = 8'h7a;
   localparam logic [7:0] CH_Q = 8'h71;
   localparam logic [6:0] UPPER_A = 7'h41;

   localparam logic [4:0] LETTER_Q = 5'd16;
   localparam logic [4:0] LETTER_X = 5'd23;
   localparam logic [4:0] CELLS = 5'd25;
   localparam logic [4:0] LAST_FILL = 5'd24;
   localparam int LETTERS = 26;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [6:0] first_out;
      logic [6:0] second_out;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic place;
      logic fill_step;
      logic msg;
      logic msg_end;
      logic look_a;
      logic look_b;
      logic pair;
      logic cell_two;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       code_ok;
      logic       complete;
      logic       pending;
      logic       fill_last;
      logic       rsp_free;
   } status_type;

   // letter code placed at step k of the alphabetical fill (q is skipped)
   function automatic logic [4:0] fill_code(input logic [4:0] k);
      return (k < LETTER_Q) ? k : k + 5'd1;
   endfunction

   function automatic logic [2:0] cell_row(input logic [4:0] c);
      logic [2:0] r;
      if (c >= 5'd20) r = 3'd4;
      else if (c >= 5'd15) r = 3'd3;
      else if (c >= 5'd10) r = 3'd2;
      else if (c >= 5'd5) r = 3'd1;
      else r = 3'd0;
      return r;
   endfunction

   function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
      return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] c);
      logic [4:0] base;
      logic [4:0] diff;
      base = cell_at(cell_row(c), 3'd0);
      diff = c - base;
      return diff[2:0];
   endfunction

   function automatic logic [2:0] next5(input logic [2:0] v);
      return (v == 3'd4) ? 3'd0 : v + 3'd1;
   endfunction

   function automatic logic [6:0] upper(input logic [4:0] code);
      return UPPER_A + {2'b00, code};
   endfunction

endpackage

[hdl/pfe_ram.sv]
// generic single-port-write ram with registered read
module pfe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pfe_ctrl.sv]
// controller state machine of the playfair encryption block
`include "playfair_encrypt_macros.svh"

module pfe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pfe_pkg::status_type st,
   output pfe_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FILL = 4'd2;
   localparam logic [3:0] S_MSG = 4'd3;
   localparam logic [3:0] S_LOOK_A = 4'd4;
   localparam logic [3:0] S_LOOK_B = 4'd5;
   localparam logic [3:0] S_PAIR = 4'd6;
   localparam logic [3:0] S_CELL_TWO = 4'd7;
   localparam logic [3:0] S_EMIT = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (st.op)
               pfe_pkg::OP_KEY: begin
                  cmd.place = 1'b1;
                  state_in = S_IDLE;
               end
               pfe_pkg::OP_KEY_DONE: begin
                  state_in = st.complete ? S_IDLE : S_FILL;
               end
               pfe_pkg::OP_MSG: begin
                  state_in = st.complete ? S_MSG : S_FILL;
               end
               default: begin
                  if (st.pending && st.complete) begin
                     cmd.msg_end = 1'b1;
                     state_in = S_LOOK_A;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (st.fill_last) begin
               state_in = (st.op == pfe_pkg::OP_MSG) ? S_MSG : S_IDLE;
            end
         end
         S_MSG: begin
            if (st.code_ok) begin
               cmd.msg = 1'b1;
               state_in = st.pending ? S_LOOK_A : S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LOOK_A: begin
            cmd.look_a = 1'b1;
            state_in = S_LOOK_B;
         end
         S_LOOK_B: begin
            cmd.look_b = 1'b1;
            state_in = S_PAIR;
         end
         S_PAIR: begin
            cmd.pair = 1'b1;
            state_in = S_CELL_TWO;
         end
         S_CELL_TWO: begin
            cmd.cell_two = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PFE_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd))
   `PFE_ASSERT_NEXT(a_emit_waits, clock, reset, (state_ff == S_EMIT) && !st.rsp_free,
      state_ff == S_EMIT)
   `PFE_ASSERT_NEXT(a_pair_follows, clock, reset, cmd.look_b, cmd.pair)

endmodule

[hdl/pfe_datapath.sv]
// key square, pairing registers and output register of the playfair block
`include "playfair_encrypt_macros.svh"

module pfe_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pfe_pkg::req_type    req_data,
   input  pfe_pkg::cmd_type    cmd,
   output pfe_pkg::status_type st,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pfe_pkg::rsp_type    rsp_data
);

   logic [1:0]  op_ff;
   logic [4:0]  code_ff;
   logic        code_ok_ff;
   logic [4:0]  fc_ff, fc_in;
   logic [pfe_pkg::LETTERS-1:0] used_ff, used_in;
   logic        complete_ff, complete_in;
   logic        pending_ff, pending_in;
   logic [4:0]  pletter_ff, pletter_in;
   logic [4:0]  k_ff, k_in;
   logic [4:0]  a_ff, b_ff;
   logic        last_ff;
   logic [4:0]  p_ff;
   logic [4:0]  o2_ff;
   logic [4:0]  l1_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   pfe_pkg::rsp_type rsp_ff;

   logic [7:0]  ch_diff;
   logic        ch_ok;
   logic        clear;
   logic [4:0]  fc_eff;
   logic [pfe_pkg::LETTERS-1:0] used_eff;
   logic        place_do;
   logic [4:0]  fcode;
   logic        fill_do;
   logic        wr_en;
   logic [4:0]  wr_letter;
   logic [4:0]  wr_cell;
   logic [4:0]  lc_rd_addr, lc_rd_data;
   logic [4:0]  cl_rd_addr, cl_rd_data;
   logic [2:0]  r1, c1, r2, c2;
   logic [4:0]  o1, o2;
   logic        rsp_free;

   assign ch_diff = req_data.ch - pfe_pkg::CH_A;
   assign ch_ok = (req_data.ch >= pfe_pkg::CH_A) && (req_data.ch <= pfe_pkg::CH_Z)
                  && (req_data.ch != pfe_pkg::CH_Q);

   // key letter after completion starts from an empty square
   assign clear = complete_ff;
   assign fc_eff = clear ? 5'd0 : fc_ff;
   assign used_eff = clear ? '0 : used_ff;
   assign place_do = cmd.place && code_ok_ff && (fc_eff != pfe_pkg::CELLS)
                     && !used_eff[code_ff];

   assign fcode = pfe_pkg::fill_code(k_ff);
   assign fill_do = cmd.fill_step && (fc_ff != pfe_pkg::CELLS) && !used_ff[fcode];

   assign wr_en = place_do || fill_do;
   assign wr_letter = cmd.place ? code_ff : fcode;
   assign wr_cell = cmd.place ? fc_eff : fc_ff;

   always_comb begin
      fc_in = fc_ff;
      used_in = used_ff;
      complete_in = complete_ff;
      pending_in = pending_ff;
      pletter_in = pletter_ff;
      k_in = k_ff;
      if (cmd.place) begin
         fc_in = fc_eff;
         used_in = used_eff;
         if (clear) begin
            complete_in = 1'b0;
            pending_in = 1'b0;
            pletter_in = 5'd0;
         end
         if (place_do) begin
            used_in[code_ff] = 1'b1;
            fc_in = fc_eff + 5'd1;
         end
      end
      if (cmd.fill_step) begin
         if (fill_do) begin
            used_in[fcode] = 1'b1;
            fc_in = fc_ff + 5'd1;
         end
         if (k_ff == pfe_pkg::LAST_FILL) begin
            k_in = 5'd0;
            complete_in = 1'b1;
         end else begin
            k_in = k_ff + 5'd1;
         end
      end
      if (cmd.msg) begin
         if (!pending_ff) begin
            pending_in = 1'b1;
            pletter_in = code_ff;
         end else if (code_ff != pletter_ff) begin
            pending_in = 1'b0;
            pletter_in = 5'd0;
         end
      end
      if (cmd.msg_end) begin
         pending_in = 1'b0;
         pletter_in = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= 5'd0;
         used_ff <= '0;
         complete_ff <= 1'b0;
         pending_ff <= 1'b0;
         pletter_ff <= 5'd0;
         k_ff <= 5'd0;
      end else begin
         fc_ff <= fc_in;
         used_ff <= used_in;
         complete_ff <= complete_in;
         pending_ff <= pending_in;
         pletter_ff <= pletter_in;
         k_ff <= k_in;
      end
   end

   // item and pair registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_data.op;
         code_ff <= ch_diff[4:0];
         code_ok_ff <= ch_ok;
      end
      if (cmd.msg && pending_ff) begin
         a_ff <= pletter_ff;
         b_ff <= (code_ff == pletter_ff) ? pfe_pkg::LETTER_X : code_ff;
         last_ff <= 1'b0;
      end
      if (cmd.msg_end) begin
         a_ff <= pletter_ff;
         b_ff <= pfe_pkg::LETTER_X;
         last_ff <= 1'b1;
      end
      if (cmd.look_b) begin
         p_ff <= lc_rd_data;
      end
      if (cmd.pair) begin
         o2_ff <= o2;
      end
      if (cmd.cell_two) begin
         l1_ff <= cl_rd_data;
      end
   end

   // letter to cell and cell to letter tables
   assign lc_rd_addr = cmd.look_a ? a_ff : b_ff;
   assign cl_rd_addr = cmd.pair ? o1 : o2_ff;

   pfe_ram #(.WIDTH(5), .DEPTH(pfe_pkg::LETTERS)) u_letter_cell (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_letter),
      .wr_data (wr_cell),
      .rd_addr (lc_rd_addr),
      .rd_data (lc_rd_data)
   );

   pfe_ram #(.WIDTH(5), .DEPTH(25)) u_cell_letter (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_cell),
      .wr_data (wr_letter),
      .rd_addr (cl_rd_addr),
      .rd_data (cl_rd_data)
   );

   // playfair rules on the two cells
   always_comb begin
      r1 = pfe_pkg::cell_row(p_ff);
      c1 = pfe_pkg::cell_col(p_ff);
      r2 = pfe_pkg::cell_row(lc_rd_data);
      c2 = pfe_pkg::cell_col(lc_rd_data);
      if (r1 == r2) begin
         o1 = pfe_pkg::cell_at(r1, pfe_pkg::next5(c1));
         o2 = pfe_pkg::cell_at(r2, pfe_pkg::next5(c2));
      end else if (c1 == c2) begin
         o1 = pfe_pkg::cell_at(pfe_pkg::next5(r1), c1);
         o2 = pfe_pkg::cell_at(pfe_pkg::next5(r2), c2);
      end else begin
         o1 = pfe_pkg::cell_at(r1, c2);
         o2 = pfe_pkg::cell_at(r2, c1);
      end
   end

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.first_out <= pfe_pkg::upper(l1_ff);
         rsp_ff.second_out <= pfe_pkg::upper(cl_rd_data);
         rsp_ff.last <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign st.op = op_ff;
   assign st.code_ok = code_ok_ff;
   assign st.complete = complete_ff;
   assign st.pending = pending_ff;
   assign st.fill_last = (k_ff == pfe_pkg::LAST_FILL);
   assign st.rsp_free = rsp_free;

   `PFE_ASSERT_IMPLY(a_emit_slot_free, clock, reset, cmd.emit, rsp_free)
   `PFE_ASSERT_ALWAYS(a_fill_bound, clock, reset, fc_ff <= pfe_pkg::CELLS)
   `PFE_ASSERT_IMPLY(a_complete_full, clock, reset, complete_ff, fc_ff == pfe_pkg::CELLS)
   `PFE_ASSERT_IMPLY(a_pending_complete, clock, reset, pending_ff, complete_ff)

endmodule

[hdl/playfair_encrypt.sv]
// top level of the playfair encryption block
//
// request channel (req_valid, req_ready, req_data) takes one item with op and ch:
// key letter, key done, message letter or message end. result channel
// (rsp_valid, rsp_ready, rsp_data) returns one enciphered pair in upper case,
// with last set for the pair closed by message end.
// items are taken one at a time; req_ready is high only while the controller
// is idle. a key letter is placed at dispatch; key done runs the fill unless the
// square is complete: the fill walks the 25 letters one per cycle.
// a message letter that closes a pair runs two table reads of the
// letter to cell ram, the rule step, two reads of the cell to letter ram, and
// the load of the output register; the result shows the cycle after that.
// a message letter runs the fill first if the square is not complete.
// the output register parts the two sides: a new item is accepted while a
// result waits, and only a finished pair stalls until rsp_ready frees the slot.
// reset (synchronous) empties the square, drops any pending letter and
// clears the output valid; no clearing pass is needed.
module playfair_encrypt (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfe_pkg::rsp_type rsp_data
);

   // command and status between controller and datapath
   pfe_pkg::cmd_type    cmd;
   pfe_pkg::status_type st;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   pfe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
